### rtl/rqu_pkg.sv
package rqu_pkg;

    localparam int WORD_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SMP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic hit;
    } cell_ctrl_t;

endpackage

### rtl/rqu_mod_unit.sv
module rqu_mod_unit #(
    parameter int CW = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rqu_pkg::WORD_W-1:0] dividend,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [CW-1:0]             remainder
);

    localparam int STEP_W = $clog2(rqu_pkg::WORD_W);

    logic                       running_reg, running_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [rqu_pkg::WORD_W-1:0] shift_reg, shift_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [CW:0]                trial;
    logic [CW:0]                diff;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial        = {rem_reg, shift_reg[rqu_pkg::WORD_W-1]};
        diff         = trial - {1'b0, divisor};
        running_next = running_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            running_next = 1'b1;
            step_next    = '0;
            shift_next   = dividend;
            rem_next     = '0;
        end
        else if (running_reg)
        begin
            shift_next = {shift_reg[rqu_pkg::WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = diff[CW-1:0];
            else
                rem_next = trial[CW-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(rqu_pkg::WORD_W - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/rqu_cell.sv
module rqu_cell (
    input  logic                       clk,
    input  rqu_pkg::cell_ctrl_t        ctrl,
    input  logic [rqu_pkg::WORD_W-1:0] load_value,
    input  logic [rqu_pkg::WORD_W-1:0] neighbor_value,
    output logic [rqu_pkg::WORD_W-1:0] value,
    output logic [rqu_pkg::WORD_W-1:0] tap
);

    logic [rqu_pkg::WORD_W-1:0] value_reg, value_next;
    logic [rqu_pkg::WORD_W-1:0] tap_reg, tap_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
            value_next = load_value;
        else if (ctrl.shift)
            value_next = neighbor_value;
        // masked copy so the taps can simply be or-ed together
        tap_next = ctrl.hit ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tap_reg   <= tap_next;
    end

    assign value = value_reg;
    assign tap   = tap_reg;

endmodule

### rtl/random_queue_unit.sv
// random_queue_unit: randomized queue of signed 32-bit items held in a row
// of cells, cell 0 the oldest entry.
// command channel: kind, item_value and random_word are taken at a rising
// edge with start high and busy low.
// result channel: result_value, status and entry_count are valid for one
// cycle while done is high; the receiver cannot stall, so every result
// is simply presented once and dropped.
// enqueue, any empty or full error and the unused kind code give their
// result in the cycle after the transaction and keep busy low, so such
// transactions may follow every cycle.
// dequeue and sample hold busy through the serial remainder unit
// (random_word modulo the count, one bit a cycle), a step to turn the
// remainder into a slot, a step for the cells to latch the chosen entry
// and a step to read it out; in that last step a dequeue also shifts
// every cell above the chosen slot down by one.
// done rises when the read-out step ends; the next transaction
// may be accepted in the cycle done is high.
// reset empties the queue (count zero); cell contents stay undefined and
// are never read before being written.
module random_queue_unit #(
    parameter int DEPTH = rqu_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rqu_pkg::KIND_W-1:0]          kind,
    input  logic signed [rqu_pkg::WORD_W-1:0]   item_value,
    input  logic [rqu_pkg::WORD_W-1:0]          random_word,
    output logic                                done,
    output logic signed [rqu_pkg::WORD_W-1:0]   result_value,
    output logic [rqu_pkg::STATUS_W-1:0]        status,
    output logic [rqu_pkg::COUNT_OUT_W-1:0]     entry_count
);

    localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
    localparam int IW = $clog2(DEPTH);      // slot index width

    rqu_pkg::state_t state_reg, state_next;

    logic [CW-1:0]               occ_reg, occ_next;
    logic [IW-1:0]               slot_reg, slot_next;
    logic                        deq_reg, deq_next;
    logic                        done_reg, done_next;
    logic [rqu_pkg::WORD_W-1:0]  result_reg, result_next;
    logic [rqu_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                        accept;
    logic                        enq_go;
    logic                        mod_start;
    logic                        mod_done;
    logic [CW-1:0]               mod_rem;
    logic [CW-1:0]               slot_wide;
    logic [rqu_pkg::WORD_W-1:0]  tap_or;

    logic [rqu_pkg::WORD_W-1:0]  cell_value [DEPTH];
    logic [rqu_pkg::WORD_W-1:0]  cell_tap   [DEPTH];
    rqu_pkg::cell_ctrl_t         cell_ctrl  [DEPTH];

    assign busy   = (state_reg != rqu_pkg::ST_IDLE);
    assign accept = start && !busy;

    // slot counted from the oldest entry
    assign slot_wide = occ_reg - CW'(1) - mod_rem;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        slot_next   = slot_reg;
        deq_next    = deq_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        status_next = status_reg;
        enq_go      = 1'b0;
        mod_start   = 1'b0;
        case (state_reg)
            rqu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    status_next = rqu_pkg::STATUS_OK;
                    case (kind)
                        rqu_pkg::KIND_ENQ:
                        begin
                            done_next = 1'b1;
                            if (occ_reg == CW'(DEPTH))
                                status_next = rqu_pkg::STATUS_FULL;
                            else
                            begin
                                enq_go   = 1'b1;
                                occ_next = occ_reg + CW'(1);
                            end
                        end
                        rqu_pkg::KIND_DEQ, rqu_pkg::KIND_SMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = rqu_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                deq_next   = (kind == rqu_pkg::KIND_DEQ);
                                state_next = rqu_pkg::ST_DIV;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok result, nothing changes
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            rqu_pkg::ST_DIV:
            begin
                if (mod_done)
                begin
                    slot_next  = slot_wide[IW-1:0];
                    state_next = rqu_pkg::ST_SEL;
                end
            end
            rqu_pkg::ST_SEL:
            begin
                // chosen cell latches its value into its tap this cycle
                state_next = rqu_pkg::ST_READ;
            end
            rqu_pkg::ST_READ:
            begin
                result_next = tap_or;
                done_next   = 1'b1;
                if (deq_reg)
                    occ_next = occ_reg - CW'(1);
                state_next = rqu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rqu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqu_pkg::ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        deq_reg    <= deq_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // serial remainder: random_word modulo the current count
    rqu_mod_unit #(
        .CW(CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (random_word),
        .divisor  (occ_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // row of cells; each one takes the value of the cell above on a shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[i].load  = enq_go && (CW'(i) == occ_reg);
            cell_ctrl[i].shift = (state_reg == rqu_pkg::ST_READ) && deq_reg
                                 && (IW'(i) >= slot_reg);
            cell_ctrl[i].hit   = (state_reg == rqu_pkg::ST_SEL)
                                 && (IW'(i) == slot_reg);
        end

        rqu_cell u_cell (
            .clk           (clk),
            .ctrl          (cell_ctrl[i]),
            .load_value    ($unsigned(item_value)),
            .neighbor_value(cell_value[(i + 1 < DEPTH) ? i + 1 : i]),
            .value         (cell_value[i]),
            .tap           (cell_tap[i])
        );
    end

    // only the chosen cell holds a nonzero tap
    always_comb
    begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++)
            tap_or = tap_or | cell_tap[k];
    end

    assign done         = done_reg;
    assign result_value = $signed(result_reg);
    assign status       = status_reg;
    assign entry_count  = rqu_pkg::COUNT_OUT_W'(occ_reg);

endmodule
